[hdl/engine_valve_phase_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Engine valve phase sequencer assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst_n.
// ----------------------------------------------------------------------------
`ifndef ENGINE_VALVE_PHASE_SEQUENCER_ASSERT_SVH
`define ENGINE_VALVE_PHASE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EVPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/evps_pkg.sv]
// ----------------------------------------------------------------------------
// Engine valve phase sequencer package
// Shared types, register map and phase and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package evps_pkg;

    localparam int TICK_W   = 10;
    localparam int PRES_W   = 24;
    localparam int MS_W     = 16;
    localparam int REOPEN_W = 24;
    localparam int PULSE_W  = MS_W + 1;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [3:0] {
        RT_NONE      = 4'b0001,
        RT_PRELAUNCH = 4'b0010,
        RT_BURN      = 4'b0100,
        RT_POSTBURN  = 4'b1000
    } routine_t;

    localparam logic [2:0] PH_PRELAUNCH = 3'd0;
    localparam logic [2:0] PH_BURN      = 3'd1;
    localparam logic [2:0] PH_COAST     = 3'd2;
    localparam logic [2:0] PH_DROGUE    = 3'd3;
    localparam logic [2:0] PH_MAIN      = 3'd4;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_BURN  = 2'd1;
    localparam logic [1:0] REQ_COAST = 2'd2;

    localparam logic [2:0] REG_TICK_MS        = 3'd0;
    localparam logic [2:0] REG_MAX_PRESSURE   = 3'd1;
    localparam logic [2:0] REG_VENT_OPEN_MS   = 3'd2;
    localparam logic [2:0] REG_VENT_CLOSED_MS = 3'd3;
    localparam logic [2:0] REG_BURN_MS        = 3'd4;
    localparam logic [2:0] REG_REOPEN_MS      = 3'd5;

    localparam logic [TICK_W-1:0]   RST_TICK_MS        = 10'd50;
    localparam logic [PRES_W-1:0]   RST_MAX_PRESSURE   = 24'd820000;
    localparam logic [MS_W-1:0]     RST_VENT_OPEN_MS   = 16'd1000;
    localparam logic [MS_W-1:0]     RST_VENT_CLOSED_MS = 16'd1000;
    localparam logic [MS_W-1:0]     RST_BURN_MS        = 16'd11000;
    localparam logic [REOPEN_W-1:0] RST_REOPEN_MS      = 24'd1200000;

    typedef struct packed {
        logic [TICK_W-1:0]   tick_ms;
        logic [PRES_W-1:0]   vent_threshold;
        logic [MS_W-1:0]     vent_open_ms;
        logic [MS_W-1:0]     vent_closed_ms;
        logic [MS_W-1:0]     burn_ms;
        logic [REOPEN_W-1:0] reopen_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        flight_phase;
        logic              pressure_valid;
        logic [PRES_W-1:0] tank_pressure;
        logic              launch_cmd;
    } item_t;

    typedef struct packed {
        logic       inject_open;
        logic       vent_open;
        logic [1:0] phase_request;
    } result_t;

endpackage

`default_nettype wire

[hdl/evps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Engine valve phase sequencer configuration registers
// APB-style register file holding the timing and pressure settings.
// ----------------------------------------------------------------------------
`default_nettype none

module evps_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [evps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [evps_pkg::DATA_W-1:0] pwdata,
    output logic      [evps_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output evps_pkg::cfg_t                  cfg
);
    import evps_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms           <= RST_TICK_MS;
            cfg_reg.vent_threshold    <= RST_MAX_PRESSURE;
            cfg_reg.vent_open_ms      <= RST_VENT_OPEN_MS;
            cfg_reg.vent_closed_ms    <= RST_VENT_CLOSED_MS;
            cfg_reg.burn_ms           <= RST_BURN_MS;
            cfg_reg.reopen_ms         <= RST_REOPEN_MS;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_TICK_MS:        cfg_reg.tick_ms           <= pwdata[TICK_W-1:0];
                REG_MAX_PRESSURE:   cfg_reg.vent_threshold    <= pwdata[PRES_W-1:0];
                REG_VENT_OPEN_MS:   cfg_reg.vent_open_ms      <= pwdata[MS_W-1:0];
                REG_VENT_CLOSED_MS: cfg_reg.vent_closed_ms    <= pwdata[MS_W-1:0];
                REG_BURN_MS:        cfg_reg.burn_ms           <= pwdata[MS_W-1:0];
                REG_REOPEN_MS:      cfg_reg.reopen_ms         <= pwdata[REOPEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TICK_MS:
                prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_reg.tick_ms};
            REG_MAX_PRESSURE:
                prdata = {{(DATA_W-PRES_W){1'b0}}, cfg_reg.vent_threshold};
            REG_VENT_OPEN_MS:
                prdata = {{(DATA_W-MS_W){1'b0}}, cfg_reg.vent_open_ms};
            REG_VENT_CLOSED_MS:
                prdata = {{(DATA_W-MS_W){1'b0}}, cfg_reg.vent_closed_ms};
            REG_BURN_MS:
                prdata = {{(DATA_W-MS_W){1'b0}}, cfg_reg.burn_ms};
            REG_REOPEN_MS:
                prdata = {{(DATA_W-REOPEN_W){1'b0}}, cfg_reg.reopen_ms};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/evps_core.sv]
// ----------------------------------------------------------------------------
// Engine valve phase sequencer core
// Routine state, timers and valve drive, advanced by one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module evps_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire evps_pkg::item_t item,
    input  wire evps_pkg::cfg_t  cfg,
    output evps_pkg::result_t   result
);
    import evps_pkg::*;

    routine_t              routine_reg, routine_next;
    logic                  held_valid_reg, held_valid_next;
    logic [PRES_W-1:0]     held_pressure_reg, held_pressure_next;
    logic [PULSE_W-1:0]    vent_timer_reg, vent_timer_next;
    logic [MS_W-1:0]       burn_elapsed_reg, burn_elapsed_next;
    logic [REOPEN_W-1:0]   postburn_elapsed_reg, postburn_elapsed_next;
    logic                  inject_reg, inject_next;
    logic                  vent_reg, vent_next;
    logic [1:0]            request;

    logic [MS_W:0]         burn_sum;
    logic [REOPEN_W:0]     post_base;
    logic [REOPEN_W:0]     post_sum;
    logic [PULSE_W-1:0]    pulse_len;
    logic [PULSE_W-1:0]    tick_ext;
    logic                  is_postburn_phase;

    assign burn_sum  = {1'b0, burn_elapsed_reg} + {{(MS_W+1-TICK_W){1'b0}}, cfg.tick_ms};
    assign post_base = (routine_reg == RT_POSTBURN) ? {1'b0, postburn_elapsed_reg} : '0;
    assign post_sum  = post_base + {{(REOPEN_W+1-TICK_W){1'b0}}, cfg.tick_ms};
    assign pulse_len = {1'b0, cfg.vent_closed_ms} + {1'b0, cfg.vent_open_ms};
    assign tick_ext  = {{(PULSE_W-TICK_W){1'b0}}, cfg.tick_ms};

    assign is_postburn_phase = (item.flight_phase == PH_COAST)
                            || (item.flight_phase == PH_DROGUE)
                            || (item.flight_phase == PH_MAIN);

    always_comb
    begin
        routine_next          = routine_reg;
        held_valid_next       = held_valid_reg;
        held_pressure_next    = held_pressure_reg;
        vent_timer_next       = vent_timer_reg;
        burn_elapsed_next     = burn_elapsed_reg;
        postburn_elapsed_next = postburn_elapsed_reg;
        inject_next           = inject_reg;
        vent_next             = vent_reg;
        request               = REQ_NONE;

        if (routine_reg == RT_BURN)
        begin
            burn_elapsed_next = burn_sum[MS_W] ? {MS_W{1'b1}} : burn_sum[MS_W-1:0];
        end
        else if (item.flight_phase == PH_PRELAUNCH)
        begin
            // A fresh entry forgets the held reading and any pulse in progress.
            if (routine_reg != RT_PRELAUNCH)
            begin
                routine_next    = RT_PRELAUNCH;
                held_valid_next = 1'b0;
                vent_timer_next = '0;
                inject_next     = 1'b0;
            end
            if (vent_timer_next == '0)
            begin
                if (item.pressure_valid)
                begin
                    held_valid_next    = 1'b1;
                    held_pressure_next = item.tank_pressure;
                end
                if (held_valid_next && (held_pressure_next > cfg.vent_threshold))
                begin
                    vent_timer_next = pulse_len;
                end
            end
            if (vent_timer_next != '0)
            begin
                vent_next = (vent_timer_next > {1'b0, cfg.vent_closed_ms});
                // The pulse ends once the remaining time reaches or passes zero.
                vent_timer_next = (vent_timer_next > tick_ext) ? vent_timer_next - tick_ext
                                                               : '0;
            end
            request = item.launch_cmd ? REQ_BURN : REQ_NONE;
        end
        else if (item.flight_phase == PH_BURN)
        begin
            routine_next      = RT_BURN;
            vent_next         = 1'b0;
            inject_next       = 1'b1;
            burn_elapsed_next = '0;
        end
        else if (is_postburn_phase)
        begin
            routine_next          = RT_POSTBURN;
            postburn_elapsed_next = post_sum[REOPEN_W] ? {REOPEN_W{1'b1}}
                                                       : post_sum[REOPEN_W-1:0];
            inject_next           = (postburn_elapsed_next >= cfg.reopen_ms);
        end
        else
        begin
            routine_next = RT_NONE;
        end

        if ((routine_next == RT_BURN) && (burn_elapsed_next >= cfg.burn_ms))
        begin
            request      = REQ_COAST;
            routine_next = RT_NONE;
        end
    end

    assign result.inject_open   = inject_next;
    assign result.vent_open     = vent_next;
    assign result.phase_request = request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            routine_reg          <= RT_NONE;
            held_valid_reg       <= 1'b0;
            vent_timer_reg       <= '0;
            burn_elapsed_reg     <= '0;
            postburn_elapsed_reg <= '0;
            inject_reg           <= 1'b0;
            vent_reg             <= 1'b0;
        end
        else if (step)
        begin
            routine_reg          <= routine_next;
            held_valid_reg       <= held_valid_next;
            vent_timer_reg       <= vent_timer_next;
            burn_elapsed_reg     <= burn_elapsed_next;
            postburn_elapsed_reg <= postburn_elapsed_next;
            inject_reg           <= inject_next;
            vent_reg             <= vent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_pressure_reg <= held_pressure_next;
        end
    end

`include "engine_valve_phase_sequencer_assert.svh"

    `EVPS_ASSERT_SAME(a_burn_valves, routine_reg == RT_BURN, inject_reg && !vent_reg, "burn routine without injection open and vent closed")
    `EVPS_ASSERT_SAME(a_pulse_needs_reading, vent_timer_reg != '0, held_valid_reg, "vent pulse running without a held pressure reading")
    `EVPS_ASSERT_SAME(a_coast_after_burn, step && (request == REQ_COAST), inject_next && !vent_next, "coast requested with the valves not in burn drive")
    `EVPS_ASSERT_NEXT(a_burn_exit, step && (routine_reg == RT_BURN), (routine_reg == RT_BURN) || (routine_reg == RT_NONE), "burn routine left to a routine other than none")

endmodule

`default_nettype wire

[hdl/engine_valve_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// Engine valve phase sequencer
// Drives the injection and vent valves from flight phase ticks.
// ----------------------------------------------------------------------------
// One request is one time tick. The block takes a tick in every clock cycle
// while the core is not stalled; each tick is captured in an input register,
// evaluated by the core when it steps and held in a result register until it
// is taken. The core only stalls when the result register is full and not
// being read. Configuration registers sit on the APB port at byte addresses
// 4*i and should only be written while no tick is in flight.
`default_nettype none

module engine_valve_phase_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [evps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [evps_pkg::DATA_W-1:0]   pwdata,
    output logic      [evps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [2:0]                    flight_phase,
    input  wire logic                          pressure_valid,
    input  wire logic [evps_pkg::PRES_W-1:0]   tank_pressure,
    input  wire logic                          launch_cmd,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic                               inject_open,
    output logic                               vent_open,
    output logic [1:0]                         phase_request
);
    import evps_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    accept;

    evps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    evps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // The core steps when a tick is waiting and the result slot is free or draining.
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.flight_phase   <= flight_phase;
            item_reg.pressure_valid <= pressure_valid;
            item_reg.tank_pressure  <= tank_pressure;
            item_reg.launch_cmd     <= launch_cmd;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid  = out_valid_reg;
    assign inject_open   = result_reg.inject_open;
    assign vent_open     = result_reg.vent_open;
    assign phase_request = result_reg.phase_request;

`include "engine_valve_phase_sequencer_assert.svh"

    `EVPS_ASSERT_NEXT(a_accept_fills, accept, in_valid_reg, "accepted tick not held in the input register")
    `EVPS_ASSERT_NEXT(a_step_fills, advance, out_valid_reg, "core step did not produce a result")
    `EVPS_ASSERT_SAME(a_stall_cause, !item_ready, in_valid_reg && out_valid_reg && !result_ready, "input stalled while the pipeline can move")

endmodule

`default_nettype wire
